### hdl/trigger_to_frame_lookup_builder_core_defines.svh
// Assertion macros used by the checker file.
`ifndef TRIGGER_TO_FRAME_LOOKUP_BUILDER_CORE_DEFINES_SVH
`define TRIGGER_TO_FRAME_LOOKUP_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define TFLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define TFLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tflb_pkg.sv
`timescale 1ns / 1ps
package tflb_pkg;

  localparam int VAL_W = 32;
  localparam int ANS_W = 13;

  typedef logic [VAL_W-1:0]        value_t;
  typedef logic [1:0]              status_t;
  typedef logic signed [ANS_W-1:0] answer_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_WIDE      = 2'd1;
  localparam status_t STATUS_NOT_BUILT = 2'd2;

  localparam answer_t ANS_MISS = '1;  // -1
  localparam answer_t ANS_ZERO = '0;

endpackage

### hdl/trigger_to_frame_lookup_builder_core.sv
`timescale 1ns / 1ps
// Trigger-to-frame lookup builder.
// Command channel: start/busy with cmd_i, value_i, last_i; a transaction is taken
// when start is high and busy is low. Result channel: res_valid_o pulses one cycle
// with kind_o, status_o, answer_o; the receiver cannot stall it.
// Config: cfg_we_i writes cfg_wdata_i into the trigger offset; the user writes it
// only while idle, as the block itself does not enforce it. Loads (cmd 0) leave
// the block idle and give no result, except the load marked last, which starts the
// table build and ends with one build-status result. Build, with N frames kept
// and S = max - min + 1: a min/max walk over the N frames in the frame memory, a
// span check, then, if S fits, a clear of S entries, a scatter and a gap fill.
// The walks share one index counter and the single read port of each memory.
// Query (cmd 1): offset subtract, table read, then the registered result;
// a query with no table built answers in the next cycle.
// Reset empties the frame list and drops the table; memories are not cleared,
// since nothing reads an entry before it is written.
module trigger_to_frame_lookup_builder_core #(
  parameter int MAX_FRAMES  = 4096,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  tflb_pkg::value_t  value_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  tflb_pkg::value_t  cfg_wdata_i,
  output logic              res_valid_o,
  output logic              kind_o,
  output tflb_pkg::status_t status_o,
  output tflb_pkg::answer_t answer_o
);
  import tflb_pkg::*;

  localparam int FA_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TA_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W  = (FCNT_W > TCNT_W) ? FCNT_W : TCNT_W;
  localparam int ENT_W  = ANS_W + 1;  // gap flag on top of the answer

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MM   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_SCAT = 3'd4;
  localparam logic [2:0] ST_FILL = 3'd5;
  localparam logic [2:0] ST_QRY  = 3'd6;
  localparam logic [2:0] ST_QOUT = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  pidx_q, pidx_d;
  logic [CNT_W-1:0]  lastgood_q, lastgood_d;
  logic              pv_q, pv_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic [TCNT_W-1:0] span_q, span_d;
  value_t            lo_q, lo_d, hi_q, hi_d;
  value_t            t_q, t_d;
  value_t            offset_q;
  logic              qhit_q, qhit_d;
  logic              ready_q, ready_d;
  logic              closed_q, closed_d;
  logic              rv_q, rv_d;
  logic              kind_q, kind_d;
  status_t           status_q, status_d;
  answer_t           answer_q, answer_d;

  // frame memory
  value_t            frame_mem [MAX_FRAMES];
  logic              fm_we;
  logic [FA_W-1:0]   fm_waddr;
  logic [FA_W-1:0]   fm_raddr;
  value_t            fm_rdata_q;

  // inverse table
  logic [ENT_W-1:0]  tbl_mem [TABLE_DEPTH];
  logic              tw_we;
  logic [TA_W-1:0]   tw_addr;
  logic [ENT_W-1:0]  tw_data;
  logic [TA_W-1:0]   tr_addr;
  logic [ENT_W-1:0]  tr_rdata_q;

  logic              accept;
  logic              frames_left;
  logic              span_left;
  value_t            diff;

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= value_i;
    end
    fm_rdata_q <= frame_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tbl_mem[tw_addr] <= tw_data;
    end
    tr_rdata_q <= tbl_mem[tr_addr];
  end

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign frames_left = (cnt_q < CNT_W'(count_q));
  assign span_left   = (cnt_q < CNT_W'(span_q));
  assign diff        = hi_q - lo_q;
  assign fm_raddr    = cnt_q[FA_W-1:0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pidx_d     = pidx_q;
    lastgood_d = lastgood_q;
    pv_d       = 1'b0;
    count_d    = count_q;
    span_d     = span_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    t_d        = t_q;
    qhit_d     = qhit_q;
    ready_d    = ready_q;
    closed_d   = closed_q;
    rv_d       = 1'b0;
    kind_d     = kind_q;
    status_d   = status_q;
    answer_d   = answer_q;
    fm_we      = 1'b0;
    fm_waddr   = count_q[FA_W-1:0];
    tw_we      = 1'b0;
    tw_addr    = pidx_q[TA_W-1:0];
    tw_data    = {1'b1, ANS_MISS};
    tr_addr    = cnt_q[TA_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_LOAD)) begin
          if (closed_q) begin
            // first load after a build starts a fresh list
            closed_d = 1'b0;
            ready_d  = 1'b0;
            fm_we    = 1'b1;
            fm_waddr = '0;
            count_d  = FCNT_W'(1);
          end else if (count_q < FCNT_W'(MAX_FRAMES)) begin
            fm_we   = 1'b1;
            count_d = count_q + FCNT_W'(1);
          end
          if (last_i) begin
            cnt_d   = '0;
            lo_d    = '1;
            hi_d    = '0;
            state_d = ST_MM;
          end
        end else if (accept) begin
          if (!ready_q) begin
            rv_d     = 1'b1;
            kind_d   = KIND_QUERY;
            status_d = STATUS_NOT_BUILT;
            answer_d = ANS_MISS;
          end else begin
            t_d     = value_i - offset_q;
            state_d = ST_QRY;
          end
        end
      end

      ST_MM: begin
        if (pv_q) begin
          if (fm_rdata_q < lo_q) lo_d = fm_rdata_q;
          if (fm_rdata_q > hi_q) hi_d = fm_rdata_q;
        end
        if (frames_left) begin
          pv_d  = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!pv_q) begin
          state_d = ST_CHK;
        end
      end

      ST_CHK: begin
        if (diff >= VAL_W'(TABLE_DEPTH)) begin
          rv_d     = 1'b1;
          kind_d   = KIND_BUILD;
          status_d = STATUS_WIDE;
          answer_d = ANS_ZERO;
          ready_d  = 1'b0;
          closed_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          span_d  = TCNT_W'(diff + VAL_W'(1));
          cnt_d   = '0;
          state_d = ST_CLR;
        end
      end

      ST_CLR: begin
        if (span_left) begin
          tw_we   = 1'b1;
          tw_addr = cnt_q[TA_W-1:0];
          tw_data = {1'b1, ANS_MISS};
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          cnt_d   = '0;
          state_d = ST_SCAT;
        end
      end

      ST_SCAT: begin
        // later frames overwrite earlier ones on a shared trigger
        if (pv_q) begin
          tw_we   = 1'b1;
          tw_addr = TA_W'(fm_rdata_q - lo_q);
          tw_data = {1'b0, ANS_W'(pidx_q)};
        end
        if (frames_left) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q;
          cnt_d  = cnt_q + CNT_W'(1);
        end else if (!pv_q) begin
          cnt_d      = '0;
          lastgood_d = '0;
          state_d    = ST_FILL;
        end
      end

      ST_FILL: begin
        // read entry cnt while rewriting entry pidx behind it
        if (pv_q) begin
          if (!tr_rdata_q[ENT_W-1]) begin
            lastgood_d = pidx_q;
          end else begin
            tw_we   = 1'b1;
            tw_addr = pidx_q[TA_W-1:0];
            tw_data = {1'b1, ANS_W'(VAL_W'(lastgood_q) - VAL_W'(pidx_q))};
          end
        end
        if (span_left) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q;
          cnt_d  = cnt_q + CNT_W'(1);
        end else if (!pv_q) begin
          rv_d     = 1'b1;
          kind_d   = KIND_BUILD;
          status_d = STATUS_OK;
          answer_d = ANS_ZERO;
          ready_d  = 1'b1;
          closed_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_QRY: begin
        tr_addr = TA_W'(t_q - lo_q);
        qhit_d  = (t_q >= lo_q) && (t_q <= hi_q);
        state_d = ST_QOUT;
      end

      ST_QOUT: begin
        rv_d     = 1'b1;
        kind_d   = KIND_QUERY;
        status_d = STATUS_OK;
        answer_d = qhit_q ? answer_t'(tr_rdata_q[ANS_W-1:0]) : ANS_MISS;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      pidx_q     <= '0;
      lastgood_q <= '0;
      pv_q       <= 1'b0;
      count_q    <= '0;
      span_q     <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      ready_q    <= 1'b0;
      closed_q   <= 1'b0;
      rv_q       <= 1'b0;
      offset_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pidx_q     <= pidx_d;
      lastgood_q <= lastgood_d;
      pv_q       <= pv_d;
      count_q    <= count_d;
      span_q     <= span_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      ready_q    <= ready_d;
      closed_q   <= closed_d;
      rv_q       <= rv_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    qhit_q   <= qhit_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    answer_q <= answer_d;
  end

  assign res_valid_o = rv_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign answer_o    = answer_q;

endmodule

### hdl/tflb_checker.sv
`timescale 1ns / 1ps
`include "trigger_to_frame_lookup_builder_core_defines.svh"
module tflb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              cmd_i,
  input logic              last_i,
  input logic              res_valid_o,
  input logic              kind_o,
  input tflb_pkg::status_t status_o,
  input tflb_pkg::answer_t answer_o
);
  import tflb_pkg::*;

  logic take_query;
  logic take_plain_load;

  assign take_query      = start && !busy && (cmd_i == CMD_QUERY);
  assign take_plain_load = start && !busy && (cmd_i == CMD_LOAD) && !last_i;

  // a query answers at once or keeps the block busy until it does
  `TFLB_ASSERT_NEXT(a_query_progress, take_query, (res_valid_o && (kind_o == KIND_QUERY)) || busy, "query transaction neither answered nor pending")

  // a load without last gives no result and leaves the block idle, silently
  `TFLB_ASSERT_NEXT(a_plain_load, take_plain_load, !res_valid_o && !busy, "plain load produced a result or stalled")

  `TFLB_ASSERT_NOW(a_wide_status, res_valid_o && (status_o == STATUS_WIDE), (kind_o == KIND_BUILD) && (answer_o == ANS_ZERO), "span-too-wide result malformed")

  `TFLB_ASSERT_NOW(a_not_built, res_valid_o && (status_o == STATUS_NOT_BUILT), (kind_o == KIND_QUERY) && (answer_o == ANS_MISS), "not-built result malformed")

endmodule

bind trigger_to_frame_lookup_builder_core tflb_checker u_tflb_checker (.*);
